// File: sv/prawf_pkg.sv
// Shared types and constants of the page run allocator (exact fit, then worst fit).
// Used by prawf_ctrl, prawf_dp and the top level; depends on nothing else.
package prawf_pkg;

  localparam int ADDR_W = 20;   // page number width
  localparam int REQ_W  = 11;   // request size width
  localparam int BRK_W  = 11;   // break / limit width
  localparam int STAT_W = 2;

  localparam int NUM_PAGES_DEF  = 1024;
  localparam int MAX_ALLOCS_DEF = 256;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TBL_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  // controller -> datapath commands
  typedef struct packed {
    logic clr;        // clear one bitmap page
    logic load;       // capture the request
    logic scan;       // bitmap scan step plus free slot search step
    logic decide;     // pick the run, record the entry
    logic mark;       // set one bitmap page
    logic find;       // table walk step
    logic unmark;     // clear one bitmap page of the freed run
    logic trim_init;  // start lowering the break
    logic trim;       // break trim step
    logic emit;       // load the output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_last;
    logic scan_ready;
    logic decide_ok;
    logic run_last;
    logic find_hit;
    logic find_miss;
    logic brk_zero;
    logic trim_done;
    logic out_free;
  } sts_t;

endpackage

// File: sv/prawf_ctrl.sv
// Sequencer of the page run allocator: one state per phase of a request.
// Depends on prawf_pkg; drives the commands of prawf_dp.
module prawf_ctrl
  import prawf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_MARK   = 4'd4;
  localparam logic [3:0] S_FIND   = 4'd5;
  localparam logic [3:0] S_UNMARK = 4'd6;
  localparam logic [3:0] S_TRIM0  = 4'd7;
  localparam logic [3:0] S_TRIM   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_op_i == OP_FREE) ? S_FIND : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_ready) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = sts_i.decide_ok ? S_MARK : S_EMIT;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.run_last) state_d = S_EMIT;
      end
      S_FIND: begin
        if (sts_i.find_hit) state_d = S_UNMARK;
        else begin
          cmd_o.find = 1'b1;
          if (sts_i.find_miss) state_d = S_EMIT;
        end
      end
      S_UNMARK: begin
        cmd_o.unmark = 1'b1;
        if (sts_i.run_last) state_d = S_TRIM0;
      end
      S_TRIM0: begin
        cmd_o.trim_init = 1'b1;
        state_d = sts_i.brk_zero ? S_EMIT : S_TRIM;
      end
      S_TRIM: begin
        cmd_o.trim = 1'b1;
        if (sts_i.trim_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

endmodule

// File: sv/prawf_dp.sv
// Datapath of the page run allocator: bitmap and table memories, counters,
// run tracking, break and result registers. Depends on prawf_pkg.
module prawf_dp
  import prawf_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int MAX_ALLOCS = MAX_ALLOCS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic [REQ_W-1:0]     in_req_i,
  input  logic [ADDR_W-1:0]    in_addr_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STAT_W-1:0]    out_status_o,
  output logic [ADDR_W-1:0]    out_addr_o,
  output logic [BRK_W-1:0]     out_brk_o
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int NW = CW + 1;
  localparam int WW = ((CW > REQ_W) ? CW : REQ_W) + 1;
  localparam int SW = $clog2(MAX_ALLOCS);
  localparam int EW = PW + CW;

  // configuration
  logic [ADDR_W-1:0] start_q;
  logic [BRK_W-1:0]  limit_q;
  // request
  logic [REQ_W-1:0]  n_q;
  logic [ADDR_W-1:0] addr_q;
  // state
  logic [CW-1:0]         brk_q;
  logic [MAX_ALLOCS-1:0] valid_q;
  logic                  used_mem [NUM_PAGES];
  logic [EW-1:0]         ent_mem  [MAX_ALLOCS];
  logic                  rd_q;
  logic [EW-1:0]         ent_rd_q;
  // page pointer and its read pipeline
  logic [NW-1:0] cnt_q, end_q, evp_q;
  logic          ev_q, iss_done_q, stop_q, scan_done_q;
  // run tracking
  logic [PW-1:0] run_at_q, exact_at_q, worst_at_q;
  logic [CW-1:0] run_len_q, worst_len_q;
  logic          have_exact_q, have_worst_q;
  // table pointer and its read pipeline
  logic [SW-1:0] tcnt_q, tevi_q, slot_q;
  logic          tev_q, tiss_done_q, slot_done_q, slot_found_q;
  logic          hit_q, find_done_q;
  // result
  logic [STAT_W-1:0] res_status_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [BRK_W-1:0]  out_brk_q;

  logic [ADDR_W-1:0] off;
  logic              free_pg, fmatch, fit, grow, space_fail, decide_ok;
  logic [WW-1:0]     n_w, brk_w, lim_w, lim_raw, run_w;
  logic [PW-1:0]     at;
  logic [PW-1:0]     ent_start;
  logic [CW-1:0]     ent_len;
  logic [WW-1:0]     brk_ext;

  assign off       = addr_q - start_q;
  assign free_pg   = (evp_q < NW'(brk_q)) && !rd_q;
  assign ent_start = ent_rd_q[EW-1:CW];
  assign ent_len   = ent_rd_q[CW-1:0];
  assign fmatch    = valid_q[tevi_q] && (ADDR_W'(ent_start) == off);

  assign n_w     = WW'(n_q);
  assign brk_w   = WW'(brk_q);
  assign run_w   = WW'(run_len_q);
  assign lim_raw = WW'(limit_q);
  assign lim_w   = (lim_raw > WW'(NUM_PAGES)) ? WW'(NUM_PAGES) : lim_raw;
  assign grow    = !have_exact_q && !have_worst_q;
  assign fit     = (brk_w <= lim_w) && (n_w <= lim_w - brk_w);
  assign space_fail = (n_q == '0) || (grow && !fit);
  assign decide_ok  = !space_fail && slot_found_q;
  assign at = have_exact_q ? exact_at_q : (have_worst_q ? worst_at_q : brk_q[PW-1:0]);
  assign brk_ext = WW'(brk_q);

  assign sts_o.clr_last   = (cnt_q == NW'(NUM_PAGES - 1));
  assign sts_o.scan_ready = scan_done_q && slot_done_q;
  assign sts_o.decide_ok  = decide_ok;
  assign sts_o.run_last   = ((cnt_q + NW'(1)) == end_q);
  assign sts_o.find_hit   = hit_q;
  assign sts_o.find_miss  = find_done_q && !hit_q;
  assign sts_o.brk_zero   = (brk_q == '0);
  assign sts_o.trim_done  = stop_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;
  assign out_brk_o    = out_brk_q;

  // memories
  always_ff @(posedge clk_i) begin
    rd_q     <= used_mem[cnt_q[PW-1:0]];
    ent_rd_q <= ent_mem[tcnt_q];
    if (cmd_i.clr || cmd_i.unmark) used_mem[cnt_q[PW-1:0]] <= 1'b0;
    else if (cmd_i.mark)           used_mem[cnt_q[PW-1:0]] <= 1'b1;
    if (cmd_i.decide && decide_ok) ent_mem[slot_q] <= {at, CW'(n_q)};
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= in_req_i;
      addr_q <= in_addr_i;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_brk_q    <= brk_ext[BRK_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      limit_q <= BRK_W'(1024);
      brk_q <= '0;
      valid_q <= '0;
      cnt_q <= '0; end_q <= '0; evp_q <= '0;
      ev_q <= 1'b0; iss_done_q <= 1'b0; stop_q <= 1'b0; scan_done_q <= 1'b0;
      run_at_q <= '0; exact_at_q <= '0; worst_at_q <= '0;
      run_len_q <= '0; worst_len_q <= '0;
      have_exact_q <= 1'b0; have_worst_q <= 1'b0;
      tcnt_q <= '0; tevi_q <= '0; slot_q <= '0;
      tev_q <= 1'b0; tiss_done_q <= 1'b0; slot_done_q <= 1'b0; slot_found_q <= 1'b0;
      hit_q <= 1'b0; find_done_q <= 1'b0;
      res_status_q <= ST_OK; res_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_HEAP_START)      start_q <= cfg_data_i;
        else if (cfg_index_i == CFG_HEAP_LIMIT) limit_q <= cfg_data_i[BRK_W-1:0];
      end

      if (cmd_i.clr) cnt_q <= cnt_q + NW'(1);

      if (cmd_i.load) begin
        cnt_q <= '0; ev_q <= 1'b0; scan_done_q <= 1'b0;
        run_len_q <= '0; worst_len_q <= '0;
        have_exact_q <= 1'b0; have_worst_q <= 1'b0;
        tcnt_q <= '0; tev_q <= 1'b0; tiss_done_q <= 1'b0;
        slot_done_q <= 1'b0; slot_found_q <= 1'b0;
        hit_q <= 1'b0; find_done_q <= 1'b0;
      end

      if (cmd_i.scan) begin
        // issue page reads up to and including the break
        ev_q  <= (cnt_q <= NW'(brk_q));
        evp_q <= cnt_q;
        if (cnt_q <= NW'(brk_q)) cnt_q <= cnt_q + NW'(1);
        // evaluate the page read last cycle
        if (ev_q) begin
          if (free_pg) begin
            if (run_len_q == '0) run_at_q <= evp_q[PW-1:0];
            run_len_q <= run_len_q + CW'(1);
          end else begin
            if (run_w >= n_w) begin
              if ((run_w == n_w) && !have_exact_q) begin
                have_exact_q <= 1'b1;
                exact_at_q   <= run_at_q;
              end
              if (run_len_q > worst_len_q) begin
                have_worst_q <= 1'b1;
                worst_len_q  <= run_len_q;
                worst_at_q   <= run_at_q;
              end
            end
            run_len_q <= '0;
          end
          if (evp_q == NW'(brk_q)) scan_done_q <= 1'b1;
        end
        // first free table slot
        if (!slot_done_q) begin
          if (!valid_q[tcnt_q]) begin
            slot_q <= tcnt_q; slot_found_q <= 1'b1; slot_done_q <= 1'b1;
          end else if (tcnt_q == SW'(MAX_ALLOCS - 1)) begin
            slot_done_q <= 1'b1;
          end else begin
            tcnt_q <= tcnt_q + SW'(1);
          end
        end
      end

      if (cmd_i.decide) begin
        if (space_fail) begin
          res_status_q <= ST_NO_SPACE; res_addr_q <= '0;
        end else if (!slot_found_q) begin
          res_status_q <= ST_TBL_FULL; res_addr_q <= '0;
        end else begin
          res_status_q <= ST_OK;
          res_addr_q   <= start_q + ADDR_W'(at);
          valid_q[slot_q] <= 1'b1;
          if (grow) brk_q <= brk_q + CW'(n_q);
          cnt_q <= NW'(at);
          end_q <= NW'(at) + NW'(n_q);
        end
      end

      if (cmd_i.mark || cmd_i.unmark) cnt_q <= cnt_q + NW'(1);

      if (cmd_i.find) begin
        tev_q  <= !tiss_done_q;
        tevi_q <= tcnt_q;
        if (tcnt_q == SW'(MAX_ALLOCS - 1)) tiss_done_q <= 1'b1;
        else tcnt_q <= tcnt_q + SW'(1);
        if (tev_q && !hit_q) begin
          if (fmatch) begin
            hit_q <= 1'b1;
            valid_q[tevi_q] <= 1'b0;
            cnt_q <= NW'(off);
            end_q <= NW'(off) + NW'(ent_len);
            res_status_q <= ST_OK; res_addr_q <= '0;
          end else if (tevi_q == SW'(MAX_ALLOCS - 1)) begin
            find_done_q <= 1'b1;
            res_status_q <= ST_NOT_FOUND; res_addr_q <= '0;
          end
        end
      end

      if (cmd_i.trim_init) begin
        cnt_q <= NW'(brk_q) - NW'(1);
        ev_q <= 1'b0; iss_done_q <= 1'b0; stop_q <= 1'b0;
      end

      if (cmd_i.trim) begin
        // read downward from the top page below the break
        ev_q  <= !iss_done_q;
        evp_q <= cnt_q;
        if (!iss_done_q) begin
          if (cnt_q == '0) iss_done_q <= 1'b1;
          else cnt_q <= cnt_q - NW'(1);
        end
        if (ev_q && !stop_q) begin
          if (!rd_q) begin
            brk_q <= CW'(evp_q);
            if (evp_q == '0) stop_q <= 1'b1;
          end else begin
            stop_q <= 1'b1;
          end
        end
      end

      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

// File: sv/page_run_allocator_exact_worst_fit_unit.sv
// Page run allocator, exact fit first and worst fit second. After reset the block
// clears its used-page bitmap and holds s_axis_tready low meanwhile; configuration
// writes are taken at any time (cfg_ready_o is always high). An allocate walks the
// bitmap one page per cycle up to and including the break and waits for the free
// table slot search to end; it then chooses the run in the decide state and marks
// the run's pages one per cycle. A free walks the allocation table one entry per
// cycle, clears the run one page per cycle and lowers the break one page per cycle
// while the top pages are free. The bitmap walks are paced by the single bitmap
// memory port. One request is worked on at a time; a finished result sits in an
// output register, so the next request is accepted while it waits on m_axis_tready.
// Depends on prawf_pkg, prawf_ctrl and prawf_dp.
module page_run_allocator_exact_worst_fit_unit
  import prawf_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int MAX_ALLOCS = MAX_ALLOCS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // [10:0] request_pages, [30:11] free_page_addr
  input  logic                 s_axis_tuser,  // [0] opcode
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // [19:0] page_addr, [30:20] break_pages
  output logic [1:0]           m_axis_tuser   // [1:0] status
);

  cmd_t              cmd;
  sts_t              sts;
  logic [ADDR_W-1:0] out_addr;
  logic [BRK_W-1:0]  out_brk;

  // config never stalls
  assign cfg_ready_o = 1'b1;

  prawf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prawf_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .MAX_ALLOCS (MAX_ALLOCS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_req_i     (s_axis_tdata[10:0]),
    .in_addr_i    (s_axis_tdata[30:11]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_addr_o   (out_addr),
    .out_brk_o    (out_brk)
  );

  // pack the result beat, zero fill the top bit
  assign m_axis_tdata = {1'b0, out_brk, out_addr};

`ifndef SYNTHESIS
  // the sequencer issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("more than one datapath command at once");

  // only a granted allocate carries a page number
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[19:0] == '0))
    else $error("page number on a refused request");

  // a result is loaded only in the cycle the previous beat leaves or the slot is empty
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule
